[hdl/srfc_pkg.sv]
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types, codes and defaults for the searchable record queue.
// ----------------------------------------------------------------------------
package srfc_pkg;

    // default sizes
    localparam int DEPTH_DEF       = 16;
    localparam int PLATE_CHARS_DEF = 6;
    localparam int GATE_BITS_DEF   = 4;

    // port field widths
    localparam int ACT_W   = 3;
    localparam int PLATE_W = 48;
    localparam int GATE_W  = 4;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    // action codes
    localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FIND    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BY_ENTRY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BY_EXIT = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    // request item
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [PLATE_W-1:0] plate;
        logic [GATE_W-1:0]  entry_gate;
        logic [GATE_W-1:0]  exit_gate;
    } req_item_t;

    // response item
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic               found;
        logic [PLATE_W-1:0] plate_out;
        logic [GATE_W-1:0]  entry_out;
        logic [GATE_W-1:0]  exit_out;
        logic [OCC_W-1:0]   occupancy;
    } rsp_item_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } srfc_state_t;

endpackage

[hdl/searchable_record_fifo_core.sv]
// ----------------------------------------------------------------------------
// searchable_record_fifo_core
// Ordered queue of vehicle records with search and removal by key.
// ----------------------------------------------------------------------------
// Usage: one request item (action, plate, entry gate, exit gate) enters on the
// req channel and exactly one response item leaves on the rsp channel, in
// order. Both channels use valid and stall; an item moves when valid is high
// and stall is low.
// Records live in one record RAM with a registered read, front at address
// zero. Append, unused codes and actions on an empty queue go straight to
// the response state. Pop, find, remove and the gate searches walk the RAM
// one record per cycle from the front until a match or the last record;
// pop and remove then shift the records behind the match down one address
// per cycle to close the gap.
// One item is worked on at a time: req_stall is high from acceptance until
// the result is written to the output register.
// The output register lets a new item be taken while a result waits; a
// stalled receiver holds the result and, once the next result is ready, the
// sequencer waits and keeps req_stall high.
// Reset clears the state, the record count and the output valid; the RAM contents are
// not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module searchable_record_fifo_core
    import srfc_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int PLATE_CHARS = PLATE_CHARS_DEF,
    parameter int GATE_BITS   = GATE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int PW = PLATE_CHARS * 8;
    localparam int RW = PW + 2 * GATE_BITS;
    localparam int AW = $clog2(DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    // record store: plate, entry gate, exit gate
    srfc_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer and output register
    srfc_ctrl #(
        .DEPTH       (DEPTH),
        .PLATE_CHARS (PLATE_CHARS),
        .GATE_BITS   (GATE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

[hdl/srfc_ram.sv]
// ----------------------------------------------------------------------------
// srfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/srfc_ctrl.sv]
// ----------------------------------------------------------------------------
// srfc_ctrl
// Sequencer for the record queue: appends, walks the record memory for
// searches, shifts records down to close a gap, and holds the output item.
// ----------------------------------------------------------------------------
module srfc_ctrl
    import srfc_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int PLATE_CHARS = PLATE_CHARS_DEF,
    parameter int GATE_BITS   = GATE_BITS_DEF,
    localparam int PW         = PLATE_CHARS * 8,
    localparam int RW         = PW + 2 * GATE_BITS,
    localparam int AW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  req_item_t     req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsp_item_t     rsp,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [RW-1:0] ram_wdata,
    output logic [AW-1:0] ram_raddr,
    input  logic [RW-1:0] ram_rdata
);

    srfc_state_t           state_reg, state_next;
    logic [ACT_W-1:0]      act_reg, act_next;
    logic [PW-1:0]         key_plate_reg, key_plate_next;
    logic [GATE_BITS-1:0]  key_entry_reg, key_entry_next;
    logic [GATE_BITS-1:0]  key_exit_reg, key_exit_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         pos_reg, pos_next;
    rsp_item_t             res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_item_t             out_item_reg, out_item_next;

    // masked request fields
    logic [63:0]           req_plate_ext;
    logic [7:0]            req_entry_ext, req_exit_ext;
    logic [PW-1:0]         in_plate;
    logic [GATE_BITS-1:0]  in_entry, in_exit;

    // fields of the record just read
    logic [PW-1:0]         rd_plate;
    logic [GATE_BITS-1:0]  rd_entry, rd_exit;
    logic [63:0]           rd_plate_ext;
    logic [7:0]            rd_entry_ext, rd_exit_ext;

    // position arithmetic
    logic [CW:0]           pos_p1, pos_p2, count_ext;
    logic                  p1_in, p2_in;
    logic                  hit;
    logic [31:0]           occ_ext;

    assign req_plate_ext = 64'(req.plate);
    assign req_entry_ext = 8'(req.entry_gate);
    assign req_exit_ext  = 8'(req.exit_gate);
    assign in_plate      = req_plate_ext[PW-1:0];
    assign in_entry      = req_entry_ext[GATE_BITS-1:0];
    assign in_exit       = req_exit_ext[GATE_BITS-1:0];

    assign rd_plate      = ram_rdata[RW-1 -: PW];
    assign rd_entry      = ram_rdata[2*GATE_BITS-1 -: GATE_BITS];
    assign rd_exit       = ram_rdata[GATE_BITS-1:0];
    assign rd_plate_ext  = 64'(rd_plate);
    assign rd_entry_ext  = 8'(rd_entry);
    assign rd_exit_ext   = 8'(rd_exit);

    assign count_ext = (CW+1)'(count_reg);
    assign pos_p1    = (CW+1)'(pos_reg) + (CW+1)'(1);
    assign pos_p2    = (CW+1)'(pos_reg) + (CW+1)'(2);
    assign p1_in     = (pos_p1 < count_ext);
    assign p2_in     = (pos_p2 < count_ext);
    assign occ_ext   = 32'(count_reg);

    // key compare against the record read this cycle
    always_comb
    begin
        case (act_reg)
            ACT_POP:      hit = 1'b1;
            ACT_FIND,
            ACT_REMOVE:   hit = (rd_plate == key_plate_reg);
            ACT_BY_ENTRY: hit = (rd_entry == key_entry_reg);
            ACT_BY_EXIT:  hit = (rd_exit == key_exit_reg);
            default:      hit = 1'b0;
        endcase
    end

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        key_plate_reg <= key_plate_next;
        key_entry_reg <= key_entry_next;
        key_exit_reg  <= key_exit_next;
        pos_reg       <= pos_next;
        res_reg       <= res_next;
        out_item_reg  <= out_item_next;
    end

    // next state and memory control
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        key_plate_next = key_plate_reg;
        key_entry_next = key_entry_reg;
        key_exit_next  = key_exit_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = {in_plate, in_entry, in_exit};
        ram_raddr      = '0;

        // output register drains when taken
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // front record is read speculatively every idle cycle
                ram_raddr = '0;
                if (req_valid)
                begin
                    act_next       = req.action;
                    key_plate_next = in_plate;
                    key_entry_next = in_entry;
                    key_exit_next  = in_exit;
                    pos_next       = '0;
                    res_next       = '0;
                    res_next.status = ST_OK;
                    state_next     = S_RESP;
                    if (req.action == ACT_APPEND)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (req.action > ACT_BY_EXIT)
                    begin
                        res_next.status = ST_OK;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read ahead the next record while testing this one
                ram_raddr = p1_in ? pos_p1[AW-1:0] : '0;
                if (hit)
                begin
                    res_next.status    = ST_OK;
                    res_next.found     = (act_reg != ACT_POP);
                    res_next.plate_out = rd_plate_ext[PLATE_W-1:0];
                    res_next.entry_out = rd_entry_ext[GATE_W-1:0];
                    res_next.exit_out  = rd_exit_ext[GATE_W-1:0];
                    if (act_reg == ACT_POP || act_reg == ACT_REMOVE)
                    begin
                        if (p1_in)
                        begin
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (!p1_in)
                begin
                    res_next.status = ST_MISS;
                    state_next      = S_RESP;
                end
                else
                begin
                    pos_next = pos_p1[AW-1:0];
                end
            end

            S_SHIFT:
            begin
                // record at pos+1 moves down to pos
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = ram_rdata;
                ram_raddr = p2_in ? pos_p2[AW-1:0] : '0;
                if (p2_in)
                begin
                    pos_next = pos_p1[AW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_item_next           = res_reg;
                    out_item_next.occupancy = occ_ext[OCC_W-1:0];
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the searchable record queue. A directed table takes
// the queue through the empty, hit, miss, duplicate-plate, full and
// tail-removal cases. Random fill and drain sequences then run under four
// handshake idling phases. A behavioral queue model predicts the responses of
// rows without a fixed answer and of random items, and each response is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import srfc_pkg::*;

    // action codes that the block ignores
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS   = 1650;
    localparam int PHASES         = 4;
    localparam int SETTLE_CYCLES  = 2 * DEPTH_DEF + 8;

    localparam logic [PLATE_W-1:0] PLATE_ONES = {PLATE_W{1'b1}};
    localparam logic [PLATE_W-1:0] PLATE_ABC  = 48'h4142_4331_3233;
    localparam logic [PLATE_W-1:0] PLATE_TAIL = 48'h5859_3939_3939;
    localparam logic [PLATE_W-1:0] PLATE_NONE = 48'h0000_0000_0001;
    localparam logic [GATE_W-1:0]  GATE_ONES  = {GATE_W{1'b1}};

    // one parked vehicle
    typedef struct packed {
        logic [PLATE_W-1:0] plate;
        logic [GATE_W-1:0]  entry_gate;
        logic [GATE_W-1:0]  exit_gate;
    } vehicle_t;

    // one row of the directed table
    typedef struct {
        req_item_t stim;
        int        reps;
        bit        known;
        rsp_item_t answer;
    } plan_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    vehicle_t  lot_model[$];
    rsp_item_t results_due[$];
    plan_row_t plan[$];

    int send_plan[PHASES] = '{0, 58, 0, 22};
    int recv_plan[PHASES] = '{0, 0, 58, 22};
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit filling = 1'b1;

    int mismatch_count = 0;
    int results_seen = 0;
    int full_refused = 0;
    int search_hits = 0;
    int act_count[8] = '{default: 0};

    searchable_record_fifo_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    always #2 clk = ~clk;

    // queue model: one response per request
    function automatic rsp_item_t lot_step(req_item_t r);
        rsp_item_t o;
        int        hit_at;
        o = '0;
        hit_at = -1;
        if (r.action == ACT_APPEND)
        begin
            if (lot_model.size() >= DEPTH_DEF)
                o.status = ST_FULL;
            else
                lot_model.push_back('{r.plate, r.entry_gate, r.exit_gate});
        end
        else if (r.action > ACT_BY_EXIT)
        begin
            o.status = ST_OK;
        end
        else if (lot_model.size() == 0)
        begin
            o.status = ST_EMPTY;
        end
        else if (r.action == ACT_POP)
        begin
            o.plate_out = lot_model[0].plate;
            o.entry_out = lot_model[0].entry_gate;
            o.exit_out = lot_model[0].exit_gate;
            void'(lot_model.pop_front());
        end
        else
        begin
            // oldest match wins
            for (int i = 0; i < lot_model.size() && hit_at < 0; i++)
            begin
                case (r.action)
                    ACT_FIND, ACT_REMOVE:
                        if (lot_model[i].plate == r.plate) hit_at = i;
                    ACT_BY_ENTRY:
                        if (lot_model[i].entry_gate == r.entry_gate) hit_at = i;
                    default:
                        if (lot_model[i].exit_gate == r.exit_gate) hit_at = i;
                endcase
            end
            if (hit_at < 0)
                o.status = ST_MISS;
            else
            begin
                o.found = 1'b1;
                o.plate_out = lot_model[hit_at].plate;
                o.entry_out = lot_model[hit_at].entry_gate;
                o.exit_out = lot_model[hit_at].exit_gate;
                if (r.action == ACT_REMOVE)
                    lot_model.delete(hit_at);
            end
        end
        o.occupancy = OCC_W'(lot_model.size());
        return o;
    endfunction

    // table rows
    function automatic void add_checked(logic [ACT_W-1:0] act, logic [PLATE_W-1:0] plate,
                                        logic [GATE_W-1:0] eg, logic [GATE_W-1:0] xg,
                                        int reps);
        plan_row_t r;
        r.stim = '{act, plate, eg, xg};
        r.reps = reps;
        r.known = 1'b0;
        r.answer = '0;
        plan.push_back(r);
    endfunction

    function automatic void add_known(logic [ACT_W-1:0] act, logic [PLATE_W-1:0] plate,
                                      logic [GATE_W-1:0] eg, logic [GATE_W-1:0] xg,
                                      logic [STAT_W-1:0] st, logic hit,
                                      logic [PLATE_W-1:0] p_o, logic [GATE_W-1:0] e_o,
                                      logic [GATE_W-1:0] x_o, logic [OCC_W-1:0] occ);
        plan_row_t r;
        r.stim = '{act, plate, eg, xg};
        r.reps = 1;
        r.known = 1'b1;
        r.answer = '{st, hit, p_o, e_o, x_o, occ};
        plan.push_back(r);
    endfunction

    function automatic logic [PLATE_W-1:0] random_plate();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[PLATE_W-1:0];
    endfunction

    // mismatch report, one line each
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %0t ns: response %0d %s got 0x%0h want 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    // drive one request item and log its expected response on acceptance
    task automatic send_item(req_item_t item, bit known, rsp_item_t answer);
        rsp_item_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        predicted = lot_step(item);
        results_due.push_back(known ? answer : predicted);
        act_count[item.action]++;
        if (predicted.status == ST_FULL)
            full_refused++;
        if (predicted.found)
            search_hits++;
        @(negedge clk);
    endtask

    // hold off until every outstanding response has come back
    task automatic wait_results_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
    endtask

    // random item: fill and drain runs, keys mostly taken from parked records
    task automatic make_random_item(output req_item_t r);
        int unsigned roll;
        int          fill;
        vehicle_t    v;
        fill = lot_model.size();
        if (filling && fill >= DEPTH_DEF && $urandom_range(2) == 0)
            filling = 1'b0;
        else if (!filling && fill == 0 && $urandom_range(2) == 0)
            filling = 1'b1;
        else if ($urandom_range(49) == 0)
            filling = !filling;
        r.plate = random_plate();
        r.entry_gate = GATE_W'($urandom_range(GATE_ONES));
        r.exit_gate = GATE_W'($urandom_range(GATE_ONES));
        roll = $urandom_range(99);
        if (roll < 3)
            r.action = roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        else if (roll < (filling ? 60 : 15))
            r.action = ACT_APPEND;
        else
            r.action = ACT_W'($urandom_range(ACT_BY_EXIT, ACT_POP));
        if (fill > 0)
        begin
            v = lot_model[$urandom_range(fill - 1)];
            roll = $urandom_range(99);
            // duplicate plates now and then so removal picks the oldest
            if (r.action == ACT_APPEND && roll < 20)
                r.plate = v.plate;
            else if (r.action != ACT_APPEND && roll < 75)
            begin
                r.plate = v.plate;
                r.entry_gate = v.entry_gate;
                r.exit_gate = v.exit_gate;
            end
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (results_due.size() == 0)
                report_mismatch("with nothing expected, status", rsp.status, 0);
            else
            begin
                if (rsp.status !== results_due[0].status)
                    report_mismatch("status", rsp.status, results_due[0].status);
                if (rsp.found !== results_due[0].found)
                    report_mismatch("found", rsp.found, results_due[0].found);
                if (rsp.plate_out !== results_due[0].plate_out)
                    report_mismatch("plate_out", rsp.plate_out, results_due[0].plate_out);
                if (rsp.entry_out !== results_due[0].entry_out)
                    report_mismatch("entry_out", rsp.entry_out, results_due[0].entry_out);
                if (rsp.exit_out !== results_due[0].exit_out)
                    report_mismatch("exit_out", rsp.exit_out, results_due[0].exit_out);
                if (rsp.occupancy !== results_due[0].occupancy)
                    report_mismatch("occupancy", rsp.occupancy, results_due[0].occupancy);
                void'(results_due.pop_front());
            end
            results_seen++;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial
    begin
        req_item_t item;
        int        useful;

        // empty queue, every action, then unused codes
        add_known(ACT_POP, '0, 4'h0, 4'h0, ST_EMPTY, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_FIND, PLATE_ONES, 4'hF, 4'hF, ST_EMPTY, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_REMOVE, PLATE_ONES, 4'h0, 4'h0, ST_EMPTY, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_BY_ENTRY, '0, 4'hF, 4'h0, ST_EMPTY, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_BY_EXIT, '0, 4'h0, 4'hF, ST_EMPTY, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_SPARE_LO, PLATE_ONES, 4'hF, 4'hF, ST_OK, 0, '0, 4'h0, 4'h0, 5'd0);
        add_known(ACT_SPARE_HI, PLATE_ONES, 4'hF, 4'hF, ST_OK, 0, '0, 4'h0, 4'h0, 5'd0);
        // field extremes and a duplicate plate
        add_known(ACT_APPEND, PLATE_ONES, 4'hF, 4'hF, ST_OK, 0, '0, 4'h0, 4'h0, 5'd1);
        add_known(ACT_APPEND, '0, 4'h0, 4'h0, ST_OK, 0, '0, 4'h0, 4'h0, 5'd2);
        add_known(ACT_APPEND, PLATE_ABC, 4'h3, 4'h9, ST_OK, 0, '0, 4'h0, 4'h0, 5'd3);
        add_known(ACT_APPEND, PLATE_ONES, 4'h5, 4'h2, ST_OK, 0, '0, 4'h0, 4'h0, 5'd4);
        // hits and misses
        add_known(ACT_FIND, PLATE_ONES, 4'h0, 4'h0, ST_OK, 1, PLATE_ONES, 4'hF, 4'hF, 5'd4);
        add_known(ACT_FIND, PLATE_NONE, 4'h0, 4'h0, ST_MISS, 0, '0, 4'h0, 4'h0, 5'd4);
        add_known(ACT_BY_ENTRY, '0, 4'h3, 4'h0, ST_OK, 1, PLATE_ABC, 4'h3, 4'h9, 5'd4);
        add_known(ACT_BY_EXIT, '0, 4'h0, 4'h0, ST_OK, 1, '0, 4'h0, 4'h0, 5'd4);
        add_known(ACT_BY_ENTRY, '0, 4'h7, 4'h0, ST_MISS, 0, '0, 4'h0, 4'h0, 5'd4);
        add_known(ACT_BY_EXIT, '0, 4'h0, 4'h6, ST_MISS, 0, '0, 4'h0, 4'h0, 5'd4);
        // removal takes the oldest of two equal plates
        add_known(ACT_REMOVE, PLATE_ONES, 4'h0, 4'h0, ST_OK, 1, PLATE_ONES, 4'hF, 4'hF, 5'd3);
        add_known(ACT_FIND, PLATE_ONES, 4'h0, 4'h0, ST_OK, 1, PLATE_ONES, 4'h5, 4'h2, 5'd3);
        add_known(ACT_POP, '0, 4'h0, 4'h0, ST_OK, 0, '0, 4'h0, 4'h0, 5'd2);
        add_known(ACT_POP, '0, 4'h0, 4'h0, ST_OK, 0, PLATE_ABC, 4'h3, 4'h9, 5'd1);
        // fill up, refuse when full, then take out the tail record
        add_checked(ACT_APPEND, '0, 4'h0, 4'h0, DEPTH_DEF - 2);
        add_known(ACT_APPEND, PLATE_TAIL, 4'hA, 4'h5, ST_OK, 0, '0, 4'h0, 4'h0, 5'd16);
        add_known(ACT_APPEND, PLATE_NONE, 4'h1, 4'h1, ST_FULL, 0, '0, 4'h0, 4'h0, 5'd16);
        add_known(ACT_REMOVE, PLATE_TAIL, 4'h0, 4'h0, ST_OK, 1, PLATE_TAIL, 4'hA, 4'h5, 5'd15);
        add_checked(ACT_FIND, PLATE_TAIL, 4'h0, 4'h0, 1);

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, random content on repeated rows
        foreach (plan[i])
        begin
            for (int k = 0; k < plan[i].reps; k++)
            begin
                item = plan[i].stim;
                if (plan[i].reps > 1)
                begin
                    item.plate = random_plate();
                    item.entry_gate = GATE_W'($urandom_range(GATE_ONES));
                    item.exit_gate = GATE_W'($urandom_range(GATE_ONES));
                end
                send_item(item, plan[i].known, plan[i].answer);
            end
        end

        // random phases, each opened after the queue of responses has drained
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_results_drained();
            send_idle_pct = send_plan[ph];
            recv_stall_pct = recv_plan[ph];
            useful = 0;
            while (useful < RANDOM_ITEMS / PHASES)
            begin
                make_random_item(item);
                send_item(item, 1'b0, '0);
                if (item.action <= ACT_BY_EXIT)
                    useful++;
            end
        end

        // wind down
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered: %0d appends (%0d refused full), %0d pops, %0d plate finds,",
                 act_count[ACT_APPEND], full_refused, act_count[ACT_POP], act_count[ACT_FIND]);
        $display("  %0d removals, %0d gate searches, %0d unused codes, %0d hits, %0d responses",
                 act_count[ACT_REMOVE], act_count[ACT_BY_ENTRY] + act_count[ACT_BY_EXIT],
                 act_count[ACT_SPARE_LO] + act_count[ACT_SPARE_HI], search_hits, results_seen);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/srfc_pkg.sv
hdl/srfc_ram.sv
hdl/srfc_ctrl.sv
hdl/searchable_record_fifo_core.sv
verif/tb_top.sv
